// ===== sv/cpet_pkg.sv =====
// Shared types and codes of the collision pair event tracker.
`default_nettype none

package cpet_pkg;

    localparam int ID_W            = 6;
    localparam int MASK_W          = 64;
    localparam int MAX_OBJECTS_DEF = 64;

    // input actions
    localparam logic [1:0] ACT_OVERLAP = 2'd0;
    localparam logic [1:0] ACT_STEP    = 2'd1;
    localparam logic [1:0] ACT_REG     = 2'd2;
    localparam logic [1:0] ACT_UNREG   = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_NEW_ID = 2'd0;
    localparam logic [1:0] KIND_EVENTS = 2'd1;
    localparam logic [1:0] KIND_NO_ID  = 2'd2;

    typedef struct packed {
        logic [1:0]      action;
        logic [ID_W-1:0] first_id;
        logic [ID_W-1:0] second_id;
        logic            is_trigger;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ID_W-1:0]   object_id;
        logic [MASK_W-1:0] trigger_enter;
        logic [MASK_W-1:0] trigger_exit;
        logic [MASK_W-1:0] contact_enter;
        logic [MASK_W-1:0] contact_exit;
        logic              last;
    } t_out_beat;

endpackage

`default_nettype wire

// ===== sv/collision_pair_event_tracker.sv =====
// Top level: pair set memory, free id stack and end of step event walk.
`default_nettype none

// Usage
//   Input channel (i_in_valid / o_in_stall / i_in_beat) carries overlap reports, end of step,
//   register and unregister requests. Output channel (o_out_valid / i_out_stall / o_out_beat)
//   carries new ids, no-id errors and one event beat per changed row; last marks the final
//   beat caused by one input beat.
//   Overlap reports: one a cycle while input is not stalled. Each is a read-modify-write of
//   one row of the pair memory (one read and one write port); a row written in the previous
//   cycle is forwarded. Register: one a cycle while the output is taken; the result goes from
//   the modify stage to the output register; the popped id comes from the free stack memory.
//   End of step: walks all MAX_OBJECTS rows, one row a cycle unless the walk pauses, and
//   takes no further input beat until done; events come out in ascending row order, one row
//   held back so that last can be set.
//   Unregister: walks all rows the same way, no result.
//   Reset clears per-row valid bits at once, so all pair sets read as empty with no clearing
//   pass; the free list and id counter start empty.
//   A stalled receiver holds the output register; the walk pauses when a further event row
//   finds both the output and hold registers full, and input stalls until it resumes.

module collision_pair_event_tracker #(
    parameter int MAX_OBJECTS = cpet_pkg::MAX_OBJECTS_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire cpet_pkg::t_in_beat  i_in_beat,
    output logic                     o_out_valid,
    input  wire                      i_out_stall,
    output cpet_pkg::t_out_beat      o_out_beat
);

    localparam int RW  = MAX_OBJECTS;
    localparam int AW  = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int FCW = $clog2(MAX_OBJECTS + 1);
    localparam int ID1 = cpet_pkg::ID_W + 1;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_WALK  = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    function automatic logic [cpet_pkg::MASK_W-1:0] f_mask_ext(input logic [RW-1:0] x);
        logic [cpet_pkg::MASK_W-1:0] y;
        y         = '0;
        y[RW-1:0] = x;
        return y;
    endfunction

    function automatic logic [cpet_pkg::ID_W-1:0] f_id_ext(input logic [AW-1:0] x);
        logic [cpet_pkg::ID_W-1:0] y;
        y         = '0;
        y[AW-1:0] = x;
        return y;
    endfunction

    // memories: row = {current trig, previous trig, current contact, previous contact}
    logic [4*RW-1:0] mem_rows  [MAX_OBJECTS];
    logic [AW-1:0]   mem_stack [MAX_OBJECTS];

    // control state
    t_state           r_state,      n_state;
    logic [AW-1:0]    r_row,        n_row;
    logic [1:0]       r_walk_op,    n_walk_op;
    logic [FCW-1:0]   r_free_count, n_free_count;
    logic [FCW-1:0]   r_next_fresh, n_next_fresh;
    logic [RW-1:0]    r_in_free,    n_in_free;
    logic [RW-1:0]    r_row_vld,    n_row_vld;
    logic             r_s1_v,       n_s1_v;
    logic             r_out_v,      n_out_v;
    logic             r_hold_v,     n_hold_v;
    logic             r_wr_v;

    // payload
    logic [AW-1:0]    r_unreg_id, n_unreg_id;
    logic [1:0]       r_s1_op;
    logic [AW-1:0]    r_s1_row;
    logic [AW-1:0]    r_s1_bit;
    logic             r_s1_trig;
    logic             r_s1_pop;
    logic [1:0]       r_s1_kind;
    logic [AW-1:0]    r_s1_id;
    logic [4*RW-1:0]  r_rd;
    logic             r_rd_vld;
    logic [AW-1:0]    r_stack_rd;
    logic [AW-1:0]    r_wr_row;
    logic [4*RW-1:0]  r_wr_data;
    cpet_pkg::t_out_beat r_out,  n_out;
    cpet_pkg::t_out_beat r_hold, n_hold;

    // issue to the modify stage
    logic             iss_v;
    logic [1:0]       iss_op;
    logic [AW-1:0]    iss_row;
    logic [AW-1:0]    iss_bit;
    logic             iss_trig;
    logic             iss_pop;
    logic [1:0]       iss_kind;
    logic [AW-1:0]    iss_id;
    logic             push;

    logic             in_acc;
    logic             out_free;
    logic             s1_stall;
    logic             s1_go;
    logic             mem_we;
    logic [4*RW-1:0]  wr_data;

    logic [cpet_pkg::ID_W-1:0] id_a, id_b, id_lo, id_hi;
    logic             a_ok, b_ok;
    logic [AW-1:0]    a_idx;
    logic [FCW-1:0]   fc_m1;
    logic             pop_hit;

    logic [4*RW-1:0]  base;
    logic [RW-1:0]    ct, pt, cc, pc;
    logic [RW-1:0]    onehot;
    logic [RW-1:0]    te, tx, ce, cx;
    logic             ev_any;
    cpet_pkg::t_out_beat ev_beat;
    cpet_pkg::t_out_beat reg_beat;

    assign out_free    = !r_out_v || !i_out_stall;
    assign o_in_stall  = !((r_state == S_IDLE) && !s1_stall);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_v;
    assign o_out_beat  = r_out;

    assign id_a  = i_in_beat.first_id;
    assign id_b  = i_in_beat.second_id;
    assign a_ok  = {1'b0, id_a} < ID1'(MAX_OBJECTS);
    assign b_ok  = {1'b0, id_b} < ID1'(MAX_OBJECTS);
    assign id_lo = (id_a < id_b) ? id_a : id_b;
    assign id_hi = (id_a < id_b) ? id_b : id_a;
    assign a_idx = id_a[AW-1:0];
    assign fc_m1 = r_free_count - 1'b1;

    // a register in flight may be popping the very id being unregistered
    assign pop_hit = r_s1_v && (r_s1_op == cpet_pkg::ACT_REG) && r_s1_pop
                     && (r_stack_rd == a_idx);

    // modify stage
    always_comb begin
        if (r_wr_v && (r_wr_row == r_s1_row)) begin
            base = r_wr_data;
        end else if (r_rd_vld) begin
            base = r_rd;
        end else begin
            base = '0;
        end
        ct     = base[4*RW-1:3*RW];
        pt     = base[3*RW-1:2*RW];
        cc     = base[2*RW-1:RW];
        pc     = base[RW-1:0];
        onehot = {{(RW-1){1'b0}}, 1'b1} << r_s1_bit;
        te     = ct & ~pt;
        tx     = pt & ~ct;
        ce     = cc & ~pc;
        cx     = pc & ~cc;
        ev_any = |{te, tx, ce, cx};

        ev_beat.kind          = cpet_pkg::KIND_EVENTS;
        ev_beat.object_id     = f_id_ext(r_s1_row);
        ev_beat.trigger_enter = f_mask_ext(te);
        ev_beat.trigger_exit  = f_mask_ext(tx);
        ev_beat.contact_enter = f_mask_ext(ce);
        ev_beat.contact_exit  = f_mask_ext(cx);
        ev_beat.last          = 1'b0;

        reg_beat               = '0;
        reg_beat.kind          = r_s1_kind;
        reg_beat.object_id     = r_s1_pop ? f_id_ext(r_stack_rd) : f_id_ext(r_s1_id);
        reg_beat.last          = 1'b1;

        case (r_s1_op)
            cpet_pkg::ACT_OVERLAP: begin
                wr_data = r_s1_trig ? {ct | onehot, pt, cc, pc} : {ct, pt, cc | onehot, pc};
            end
            cpet_pkg::ACT_STEP: begin
                wr_data = {{RW{1'b0}}, ct, {RW{1'b0}}, cc};
            end
            cpet_pkg::ACT_UNREG: begin
                wr_data = (r_s1_row == r_s1_bit) ? '0 : (base & {4{~onehot}});
            end
            default: begin
                wr_data = base;
            end
        endcase

        s1_stall = r_s1_v && (
            ((r_s1_op == cpet_pkg::ACT_REG) && !out_free) ||
            ((r_s1_op == cpet_pkg::ACT_STEP) && ev_any && r_hold_v && !out_free));
        s1_go  = r_s1_v && !s1_stall;
        mem_we = s1_go && (r_s1_op != cpet_pkg::ACT_REG);
    end

    // sequencing, free list and output
    always_comb begin
        n_state      = r_state;
        n_row        = r_row;
        n_walk_op    = r_walk_op;
        n_unreg_id   = r_unreg_id;
        n_free_count = r_free_count;
        n_next_fresh = r_next_fresh;
        n_in_free    = r_in_free;
        n_row_vld    = r_row_vld;
        n_out        = r_out;
        n_hold       = r_hold;
        n_hold_v     = r_hold_v;
        n_out_v      = (r_out_v && !i_out_stall) ? 1'b0 : r_out_v;

        iss_v    = 1'b0;
        iss_op   = cpet_pkg::ACT_OVERLAP;
        iss_row  = '0;
        iss_bit  = '0;
        iss_trig = 1'b0;
        iss_pop  = 1'b0;
        iss_kind = cpet_pkg::KIND_NEW_ID;
        iss_id   = '0;
        push     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in_beat.action)
                        cpet_pkg::ACT_OVERLAP: begin
                            if ((id_a != id_b) && a_ok && b_ok) begin
                                iss_v    = 1'b1;
                                iss_op   = cpet_pkg::ACT_OVERLAP;
                                iss_row  = id_lo[AW-1:0];
                                iss_bit  = id_hi[AW-1:0];
                                iss_trig = i_in_beat.is_trigger;
                            end
                        end
                        cpet_pkg::ACT_STEP: begin
                            n_state   = S_WALK;
                            n_row     = '0;
                            n_walk_op = cpet_pkg::ACT_STEP;
                        end
                        cpet_pkg::ACT_REG: begin
                            iss_v  = 1'b1;
                            iss_op = cpet_pkg::ACT_REG;
                            if (r_free_count != '0) begin
                                iss_pop      = 1'b1;
                                n_free_count = fc_m1;
                            end else if (r_next_fresh < FCW'(MAX_OBJECTS)) begin
                                iss_id       = r_next_fresh[AW-1:0];
                                n_next_fresh = r_next_fresh + 1'b1;
                            end else begin
                                iss_kind = cpet_pkg::KIND_NO_ID;
                            end
                        end
                        cpet_pkg::ACT_UNREG: begin
                            if (a_ok) begin
                                n_state    = S_WALK;
                                n_row      = '0;
                                n_walk_op  = cpet_pkg::ACT_UNREG;
                                n_unreg_id = a_idx;
                                if (({1'b0, id_a} < ID1'(r_next_fresh))
                                    && (r_free_count < FCW'(MAX_OBJECTS))
                                    && !(r_in_free[a_idx] && !pop_hit)) begin
                                    push         = 1'b1;
                                    n_free_count = r_free_count + 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (!s1_stall) begin
                    iss_v   = 1'b1;
                    iss_op  = r_walk_op;
                    iss_row = r_row;
                    iss_bit = r_unreg_id;
                    if (r_row == AW'(MAX_OBJECTS - 1)) begin
                        n_state = (r_walk_op == cpet_pkg::ACT_STEP) ? S_FLUSH : S_IDLE;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                // last row is through; the held beat is the final one
                if (!r_s1_v) begin
                    if (!r_hold_v) begin
                        n_state = S_IDLE;
                    end else if (out_free) begin
                        n_out      = r_hold;
                        n_out.last = 1'b1;
                        n_out_v    = 1'b1;
                        n_hold_v   = 1'b0;
                        n_state    = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (s1_go) begin
            if (r_s1_op == cpet_pkg::ACT_REG) begin
                n_out   = reg_beat;
                n_out_v = 1'b1;
                if (r_s1_pop) begin
                    n_in_free[r_stack_rd] = 1'b0;
                end
            end else if ((r_s1_op == cpet_pkg::ACT_STEP) && ev_any) begin
                if (r_hold_v) begin
                    n_out   = r_hold;
                    n_out_v = 1'b1;
                end
                n_hold   = ev_beat;
                n_hold_v = 1'b1;
            end
        end
        if (mem_we) begin
            n_row_vld[r_s1_row] = 1'b1;
        end
        if (push) begin
            n_in_free[a_idx] = 1'b1;
        end

        n_s1_v = iss_v ? 1'b1 : (s1_go ? 1'b0 : r_s1_v);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_row        <= '0;
            r_walk_op    <= cpet_pkg::ACT_STEP;
            r_free_count <= '0;
            r_next_fresh <= '0;
            r_in_free    <= '0;
            r_row_vld    <= '0;
            r_s1_v       <= 1'b0;
            r_out_v      <= 1'b0;
            r_hold_v     <= 1'b0;
            r_wr_v       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_row        <= n_row;
            r_walk_op    <= n_walk_op;
            r_free_count <= n_free_count;
            r_next_fresh <= n_next_fresh;
            r_in_free    <= n_in_free;
            r_row_vld    <= n_row_vld;
            r_s1_v       <= n_s1_v;
            r_out_v      <= n_out_v;
            r_hold_v     <= n_hold_v;
            if (mem_we) begin
                r_wr_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_unreg_id <= n_unreg_id;
        r_out      <= n_out;
        r_hold     <= n_hold;
        if (iss_v) begin
            r_s1_op   <= iss_op;
            r_s1_row  <= iss_row;
            r_s1_bit  <= iss_bit;
            r_s1_trig <= iss_trig;
            r_s1_pop  <= iss_pop;
            r_s1_kind <= iss_kind;
            r_s1_id   <= iss_id;
        end
        if (mem_we) begin
            r_wr_row  <= r_s1_row;
            r_wr_data <= wr_data;
        end
    end

    // pair set memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_rows[r_s1_row] <= wr_data;
        end
        if (iss_v && (iss_op != cpet_pkg::ACT_REG)) begin
            r_rd     <= mem_rows[iss_row];
            r_rd_vld <= r_row_vld[iss_row];
        end
    end

    // free id stack
    always_ff @(posedge i_clk) begin
        if (push) begin
            mem_stack[r_free_count[AW-1:0]] <= a_idx;
        end
        if (iss_pop) begin
            r_stack_rd <= mem_stack[fc_m1[AW-1:0]];
        end
    end

endmodule

`default_nettype wire

// ===== sv/cpet_checker.sv =====
// Port level checks of the collision pair event tracker, with its bind.
`default_nettype none

module cpet_checker (
    input wire                      i_clk,
    input wire                      i_rst_n,
    input wire                      o_out_valid,
    input wire                      i_out_stall,
    input wire cpet_pkg::t_out_beat o_out_beat
);

    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output beat dropped while stalled");

    a_out_hold_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_beat))
        else $error("output beat changed while stalled");

    // id and error results stand alone and carry no masks
    a_id_result_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_beat.kind != cpet_pkg::KIND_EVENTS) |->
            o_out_beat.last && (o_out_beat.trigger_enter == '0)
            && (o_out_beat.trigger_exit == '0) && (o_out_beat.contact_enter == '0)
            && (o_out_beat.contact_exit == '0))
        else $error("id result with masks or without last");

    // only rows that changed are reported
    a_event_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_beat.kind == cpet_pkg::KIND_EVENTS) |->
            ((o_out_beat.trigger_enter | o_out_beat.trigger_exit
              | o_out_beat.contact_enter | o_out_beat.contact_exit) != '0))
        else $error("event beat with no events");

endmodule

bind collision_pair_event_tracker cpet_checker u_cpet_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_beat  (o_out_beat)
);

`default_nettype wire
